// File: sv/bata_pkg.sv
// Shared types, widths and codes for the bounded active task admitter.
`default_nettype none

package bata_pkg;

    localparam int OP_W           = 2;
    localparam int ID_W           = 6;
    localparam int STAT_W         = 3;
    localparam int CNT_W          = 7;
    localparam int ST_W           = 2;
    localparam int ID_SPACE       = 1 << ID_W;
    localparam int TASK_SLOTS_DEF = 64;
    localparam logic [CNT_W-1:0] MAX_ACTIVE_RST = 7'd1;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;
    localparam logic [OP_W-1:0] OP_STOP   = 2'd3;

    localparam logic [ST_W-1:0] ST_ABSENT  = 2'd0;
    localparam logic [ST_W-1:0] ST_STOPPED = 2'd1;
    localparam logic [ST_W-1:0] ST_WAITING = 2'd2;
    localparam logic [ST_W-1:0] ST_ACTIVE  = 2'd3;

    localparam logic [STAT_W-1:0] RC_OK            = 3'd0;
    localparam logic [STAT_W-1:0] RC_NOT_STOPPED   = 3'd1;
    localparam logic [STAT_W-1:0] RC_NOT_SCHEDULED = 3'd2;
    localparam logic [STAT_W-1:0] RC_PRESENT       = 3'd3;
    localparam logic [STAT_W-1:0] RC_ABSENT        = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [ID_W-1:0] task_id;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              promoted_valid;
        logic [ID_W-1:0]   promoted_task;
        logic [CNT_W-1:0]  active_count;
        logic [CNT_W-1:0]  waiting_count;
        logic [CNT_W-1:0]  stopped_count;
    } t_result;

endpackage

`default_nettype wire

// File: sv/bata_prio_enc.sv
// Lowest-index priority encoder over the waiting bitmap.
`default_nettype none

module bata_prio_enc #(
    parameter int N     = 64,
    parameter int IDX_W = 6
) (
    input  wire logic [N-1:0]     i_req,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_idx
);

    always_comb begin
        o_found = |i_req;
        o_idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (i_req[i]) begin
                o_idx = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/bata_slot_table.sv
// Per-slot task state, state counters, request decode and promotion.
`default_nettype none

module bata_slot_table #(
    parameter int TASK_SLOTS = bata_pkg::TASK_SLOTS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire bata_pkg::t_req              i_req,
    input  wire logic [bata_pkg::CNT_W-1:0]  i_max_active,
    output bata_pkg::t_result                o_result
);

    localparam int SLOTS = (TASK_SLOTS < bata_pkg::ID_SPACE) ? TASK_SLOTS : bata_pkg::ID_SPACE;
    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [bata_pkg::CNT_W-1:0] SLOT_LIM = bata_pkg::CNT_W'(SLOTS);

    logic [bata_pkg::ST_W-1:0]   r_state [SLOTS];
    logic [bata_pkg::CNT_W-1:0]  r_act;
    logic [bata_pkg::CNT_W-1:0]  r_wait;
    logic [bata_pkg::CNT_W-1:0]  r_stop;

    logic                        id_ok;
    logic [IDX_W-1:0]            sel;
    logic [bata_pkg::ST_W-1:0]   cur;
    logic [bata_pkg::ST_W-1:0]   nxt;
    logic                        wr;
    logic                        try_prom;
    logic [bata_pkg::STAT_W-1:0] status;
    logic [bata_pkg::CNT_W-1:0]  act_mid;
    logic [bata_pkg::CNT_W-1:0]  wait_mid;
    logic [bata_pkg::CNT_W-1:0]  stop_mid;
    logic [SLOTS-1:0]            wait_vec;
    logic                        found;
    logic [IDX_W-1:0]            pidx;
    logic                        promote;
    logic [bata_pkg::CNT_W-1:0]  n_act;
    logic [bata_pkg::CNT_W-1:0]  n_wait;

    assign id_ok = ({1'b0, i_req.task_id} < SLOT_LIM);
    assign sel   = i_req.task_id[IDX_W-1:0];
    assign cur   = id_ok ? r_state[sel] : bata_pkg::ST_ABSENT;

    always_comb begin
        wr       = 1'b0;
        nxt      = cur;
        try_prom = 1'b0;
        status   = bata_pkg::RC_OK;
        if (!id_ok) begin
            status = bata_pkg::RC_ABSENT;
        end else begin
            unique case (i_req.operation)
                bata_pkg::OP_ADD: begin
                    if (cur != bata_pkg::ST_ABSENT) begin
                        status = bata_pkg::RC_PRESENT;
                    end else begin
                        wr  = 1'b1;
                        nxt = bata_pkg::ST_STOPPED;
                    end
                end
                bata_pkg::OP_REMOVE: begin
                    if (cur == bata_pkg::ST_ABSENT) begin
                        status = bata_pkg::RC_ABSENT;
                    end else begin
                        wr       = 1'b1;
                        nxt      = bata_pkg::ST_ABSENT;
                        try_prom = (cur == bata_pkg::ST_ACTIVE);
                    end
                end
                bata_pkg::OP_START: begin
                    if (cur == bata_pkg::ST_ABSENT) begin
                        status = bata_pkg::RC_ABSENT;
                    end else if (cur != bata_pkg::ST_STOPPED) begin
                        status = bata_pkg::RC_NOT_STOPPED;
                    end else begin
                        wr       = 1'b1;
                        nxt      = bata_pkg::ST_WAITING;
                        try_prom = 1'b1;
                    end
                end
                bata_pkg::OP_STOP: begin
                    if (cur == bata_pkg::ST_ABSENT) begin
                        status = bata_pkg::RC_ABSENT;
                    end else if (cur == bata_pkg::ST_STOPPED) begin
                        status = bata_pkg::RC_NOT_SCHEDULED;
                    end else begin
                        wr       = 1'b1;
                        nxt      = bata_pkg::ST_STOPPED;
                        try_prom = (cur == bata_pkg::ST_ACTIVE);
                    end
                end
                default: begin
                    status = bata_pkg::RC_ABSENT;
                end
            endcase
        end
    end

    always_comb begin
        act_mid  = r_act  - bata_pkg::CNT_W'(wr && cur == bata_pkg::ST_ACTIVE)
                          + bata_pkg::CNT_W'(wr && nxt == bata_pkg::ST_ACTIVE);
        wait_mid = r_wait - bata_pkg::CNT_W'(wr && cur == bata_pkg::ST_WAITING)
                          + bata_pkg::CNT_W'(wr && nxt == bata_pkg::ST_WAITING);
        stop_mid = r_stop - bata_pkg::CNT_W'(wr && cur == bata_pkg::ST_STOPPED)
                          + bata_pkg::CNT_W'(wr && nxt == bata_pkg::ST_STOPPED);
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            if (wr && sel == IDX_W'(i)) begin
                wait_vec[i] = (nxt == bata_pkg::ST_WAITING);
            end else begin
                wait_vec[i] = (r_state[i] == bata_pkg::ST_WAITING);
            end
        end
    end

    bata_prio_enc #(
        .N     (SLOTS),
        .IDX_W (IDX_W)
    ) u_prio_enc (
        .i_req   (wait_vec),
        .o_found (found),
        .o_idx   (pidx)
    );

    assign promote = try_prom && found && (act_mid < i_max_active);
    assign n_act   = act_mid  + bata_pkg::CNT_W'(promote);
    assign n_wait  = wait_mid - bata_pkg::CNT_W'(promote);

    always_comb begin
        o_result.status         = status;
        o_result.promoted_valid = promote;
        o_result.promoted_task  = promote ? bata_pkg::ID_W'(pidx) : '0;
        o_result.active_count   = n_act;
        o_result.waiting_count  = n_wait;
        o_result.stopped_count  = stop_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_state[i] <= bata_pkg::ST_ABSENT;
            end
            r_act  <= '0;
            r_wait <= '0;
            r_stop <= '0;
        end else if (i_fire) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (promote && pidx == IDX_W'(i)) begin
                    r_state[i] <= bata_pkg::ST_ACTIVE;
                end else if (wr && sel == IDX_W'(i)) begin
                    r_state[i] <= nxt;
                end
            end
            r_act  <= n_act;
            r_wait <= n_wait;
            r_stop <= stop_mid;
        end
    end

endmodule

`default_nettype wire

// File: sv/bounded_active_task_admitter.sv
// Each input beat reaches its result beat through the request register and then the result register.
// Throughput: one request per cycle while the result side does not stall; each request is one slot table update plus
// a lowest-index priority encode over the waiting bitmap.
// Output stalls hold the result register and back up into the request register.
// Reset (synchronous, active low): all slots absent, all counts zero, max_active = 1;
// usable as soon as reset is released, no clearing pass.
`default_nettype none

module bounded_active_task_admitter #(
    parameter int TASK_SLOTS = bata_pkg::TASK_SLOTS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wen,
    input  wire logic [bata_pkg::CNT_W-1:0]  i_cfg_wdata,   // max_active
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [7:0]                  i_s_tdata,     // operation[1:0], task_id[7:2]
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic [31:0]                      o_m_tdata      // status[2:0], promoted_valid[3],
                                                            // promoted_task[9:4],
                                                            // active_count[16:10],
                                                            // waiting_count[23:17],
                                                            // stopped_count[30:24], zero[31]
);

    logic [bata_pkg::CNT_W-1:0]  r_max_active;
    logic                        r_in_valid;
    bata_pkg::t_req              r_req;
    logic                        r_out_valid;
    bata_pkg::t_result           r_out;
    bata_pkg::t_result           result;
    logic                        advance;
    logic                        fire;

    assign advance    = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_active <= bata_pkg::MAX_ACTIVE_RST;
        end else if (i_cfg_wen) begin
            r_max_active <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_req.operation <= i_s_tdata[1:0];
            r_req.task_id   <= i_s_tdata[7:2];
        end
    end

    bata_slot_table #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_slot_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_req        (r_req),
        .i_max_active (r_max_active),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.stopped_count, r_out.waiting_count, r_out.active_count,
                         r_out.promoted_task, r_out.promoted_valid, r_out.status};

endmodule

`default_nettype wire

// File: sv/bata_checker.sv
// Port-level checker for the bounded active task admitter, with its bind.
`default_nettype none

module bata_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata
);

    logic [8:0] total;

    assign total = 9'(o_m_tdata[16:10]) + 9'(o_m_tdata[23:17]) + 9'(o_m_tdata[30:24]);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    a_error_no_promote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] != bata_pkg::RC_OK |-> !o_m_tdata[3])
        else $error("promotion reported on a failed request");

    a_idle_task_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[3] |-> o_m_tdata[9:4] == '0)
        else $error("promoted task nonzero without promotion");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> total <= 9'(bata_pkg::ID_SPACE) && !o_m_tdata[31])
        else $error("task counts exceed slot space");

endmodule

bind bounded_active_task_admitter bata_checker u_bata_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

// File: tb/bata_admission_checker.sv
`timescale 1ns / 1ps
// Admission checker: watches request, result and config traffic, predicts each result and compares.
module bata_admission_checker #(
    parameter int TASK_SLOTS = bata_pkg::TASK_SLOTS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wen,
    input  wire logic [bata_pkg::CNT_W-1:0] i_cfg_wdata,
    input  wire logic                       i_s_tvalid,
    input  wire logic                       i_s_tready,
    input  wire logic [7:0]                 i_s_tdata,   // operation[1:0], task_id[7:2]
    input  wire logic                       i_m_tvalid,
    input  wire logic                       i_m_tready,
    input  wire logic [31:0]                i_m_tdata,   // status[2:0], promoted_valid[3],
                                                         // promoted_task[9:4],
                                                         // active_count[16:10],
                                                         // waiting_count[23:17],
                                                         // stopped_count[30:24], zero[31]
    output int                              o_fail_count,
    output int                              o_pending
);
    import bata_pkg::*;

    logic [ST_W-1:0]  slot_state [TASK_SLOTS];
    logic [CNT_W-1:0] n_active;
    logic [CNT_W-1:0] n_waiting;
    logic [CNT_W-1:0] n_stopped;
    logic [CNT_W-1:0] active_limit;
    t_result          expected_results [$];
    int               fails = 0;
    int               pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    function automatic t_result admit_request(t_req req);
        t_result         res;
        logic [ST_W-1:0] cur;
        logic            rebalance;
        int              i;
        res       = '0;
        res.status = RC_OK;
        rebalance = 1'b0;
        if (int'(req.task_id) >= TASK_SLOTS) begin
            res.status = RC_ABSENT;
        end else begin
            cur = slot_state[req.task_id];
            case (req.operation)
                OP_ADD: begin
                    if (cur != ST_ABSENT) begin
                        res.status = RC_PRESENT;
                    end else begin
                        slot_state[req.task_id] = ST_STOPPED;
                        n_stopped = n_stopped + 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (cur == ST_ABSENT) begin
                        res.status = RC_ABSENT;
                    end else begin
                        if (cur == ST_STOPPED) begin
                            n_stopped = n_stopped - 1'b1;
                        end else if (cur == ST_WAITING) begin
                            n_waiting = n_waiting - 1'b1;
                        end else begin
                            n_active  = n_active - 1'b1;
                            rebalance = 1'b1;
                        end
                        slot_state[req.task_id] = ST_ABSENT;
                    end
                end
                OP_START: begin
                    if (cur == ST_ABSENT) begin
                        res.status = RC_ABSENT;
                    end else if (cur != ST_STOPPED) begin
                        res.status = RC_NOT_STOPPED;
                    end else begin
                        slot_state[req.task_id] = ST_WAITING;
                        n_stopped = n_stopped - 1'b1;
                        n_waiting = n_waiting + 1'b1;
                        rebalance = 1'b1;
                    end
                end
                default: begin
                    if (cur == ST_ABSENT) begin
                        res.status = RC_ABSENT;
                    end else if (cur == ST_STOPPED) begin
                        res.status = RC_NOT_SCHEDULED;
                    end else begin
                        if (cur == ST_ACTIVE) begin
                            n_active  = n_active - 1'b1;
                            rebalance = 1'b1;
                        end else begin
                            n_waiting = n_waiting - 1'b1;
                        end
                        slot_state[req.task_id] = ST_STOPPED;
                        n_stopped = n_stopped + 1'b1;
                    end
                end
            endcase
        end
        if (rebalance && n_active < active_limit && n_waiting != 0) begin
            for (i = 0; i < TASK_SLOTS; i++) begin
                if (!res.promoted_valid && slot_state[i] == ST_WAITING) begin
                    slot_state[i]      = ST_ACTIVE;
                    n_waiting          = n_waiting - 1'b1;
                    n_active           = n_active + 1'b1;
                    res.promoted_valid = 1'b1;
                    res.promoted_task  = i[ID_W-1:0];
                end
            end
        end
        res.active_count  = n_active;
        res.waiting_count = n_waiting;
        res.stopped_count = n_stopped;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_req    req;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            foreach (slot_state[i]) slot_state[i] = ST_ABSENT;
            n_active     = '0;
            n_waiting    = '0;
            n_stopped    = '0;
            active_limit = MAX_ACTIVE_RST;
            expected_results.delete();
            pending = 0;
        end else begin
            if (i_cfg_wen) begin
                active_limit = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) begin
                req.operation = i_s_tdata[1:0];
                req.task_id   = i_s_tdata[7:2];
                expected_results.push_back(admit_request(req));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status         = i_m_tdata[2:0];
                got.promoted_valid = i_m_tdata[3];
                got.promoted_task  = i_m_tdata[9:4];
                got.active_count   = i_m_tdata[16:10];
                got.waiting_count  = i_m_tdata[23:17];
                got.stopped_count  = i_m_tdata[30:24];
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t: result beat with nothing expected: %h", $realtime,
                                 i_m_tdata);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  exp status=%0d pv=%0d pt=%0d act=%0d wait=%0d stop=%0d",
                                     want.status, want.promoted_valid, want.promoted_task,
                                     want.active_count, want.waiting_count,
                                     want.stopped_count);
                            $display("  got status=%0d pv=%0d pt=%0d act=%0d wait=%0d stop=%0d",
                                     got.status, got.promoted_valid, got.promoted_task,
                                     got.active_count, got.waiting_count,
                                     got.stopped_count);
                        end
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

// File: tb/bounded_active_task_admitter_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives requests, limit writes and result back-pressure, and gives the verdict.
module bounded_active_task_admitter_tb;
    import bata_pkg::*;

    localparam int RUN_LIMIT      = 400000;
    localparam int PHASES         = 8;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES    = 300;

    localparam logic [1:0] LIFE_ABSENT    = 2'd0;
    localparam logic [1:0] LIFE_STOPPED   = 2'd1;
    localparam logic [1:0] LIFE_SCHEDULED = 2'd2;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wen = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic             s_tvalid = 1'b0;
    logic [7:0]       s_tdata = '0;
    wire              s_tready;
    wire              m_tvalid;
    logic             m_tready = 1'b0;
    wire  [31:0]      m_tdata;
    int               fail_count;
    int               pending;
    int               cycles = 0;
    int               sender_idle_pct = 0;
    int               rx_stall_pct = 0;
    logic             rx_hold = 1'b0;
    int               phase_no = -1;
    logic [1:0]       life [ID_SPACE];

    bounded_active_task_admitter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wen   (cfg_wen),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    bata_admission_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wen    (cfg_wen),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("bounded_active_task_admitter_tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || rx_hold) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // hold the result side off long enough for the pipeline to fill and stall requests
    initial begin
        wait (phase_no == PRESSURE_PHASE);
        repeat (20) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic offer_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {id, op};
        do @(posedge clk); while (!s_tready);
        case (op)
            OP_ADD:    if (life[id] == LIFE_ABSENT) life[id] = LIFE_STOPPED;
            OP_REMOVE: life[id] = LIFE_ABSENT;
            OP_START:  if (life[id] == LIFE_STOPPED) life[id] = LIFE_SCHEDULED;
            default:   if (life[id] == LIFE_SCHEDULED) life[id] = LIFE_STOPPED;
        endcase
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] limit);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // mostly legal lifecycle steps on random slots, some raw noise
    task automatic pick_request(output logic [OP_W-1:0] op, output logic [ID_W-1:0] id);
        id = ID_W'($urandom_range(ID_SPACE - 1));
        if ($urandom_range(99) < 20) begin
            op = OP_W'($urandom_range(3));
        end else begin
            case (life[id])
                LIFE_ABSENT:  op = OP_ADD;
                LIFE_STOPPED: op = ($urandom_range(99) < 70) ? OP_START : OP_REMOVE;
                default:      op = ($urandom_range(99) < 60) ? OP_STOP : OP_REMOVE;
            endcase
        end
    endtask

    initial begin
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] limit;
        int               items;
        foreach (life[i]) life[i] = LIFE_ABSENT;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        offer_request(OP_ADD,    6'd0);
        offer_request(OP_ADD,    6'd0);
        offer_request(OP_START,  6'd63);
        offer_request(OP_STOP,   6'd0);
        offer_request(OP_REMOVE, 6'd63);
        offer_request(OP_STOP,   6'd63);
        offer_request(OP_START,  6'd0);
        offer_request(OP_START,  6'd0);
        offer_request(OP_ADD,    6'd63);
        offer_request(OP_START,  6'd63);
        offer_request(OP_ADD,    6'd1);
        offer_request(OP_START,  6'd1);
        offer_request(OP_STOP,   6'd0);
        offer_request(OP_REMOVE, 6'd1);
        offer_request(OP_REMOVE, 6'd0);
        offer_request(OP_STOP,   6'd63);
        offer_request(OP_START,  6'd63);
        offer_request(OP_ADD,    6'd42);
        offer_request(OP_START,  6'd42);
        offer_request(OP_REMOVE, 6'd42);
        offer_request(OP_ADD,    6'd21);
        offer_request(OP_REMOVE, 6'd63);

        for (int p = 0; p < PHASES; p++) begin
            items = 250;
            case (p)
                0: begin limit = 7'd0;   sender_idle_pct = 0;  rx_stall_pct = 0;  items = 200; end
                1: begin limit = 7'd1;   sender_idle_pct = 86; rx_stall_pct = 0;  end
                2: begin limit = 7'd2;   sender_idle_pct = 0;  rx_stall_pct = 86; end
                3: begin limit = 7'd64;  sender_idle_pct = 7;  rx_stall_pct = 7;  end
                4: begin limit = 7'd127; sender_idle_pct = 0;  rx_stall_pct = 0;  end
                5: begin limit = 7'd3;   sender_idle_pct = 0;  rx_stall_pct = 86; end
                6: begin limit = 7'd65;  sender_idle_pct = 86; rx_stall_pct = 0;  end
                default: begin
                    limit = CNT_W'($urandom_range(8, 1));
                    sender_idle_pct = 7;
                    rx_stall_pct = 7;
                    items = 300;
                end
            endcase
            write_limit(limit);
            phase_no = p;
            repeat (items) begin
                pick_request(op, id);
                offer_request(op, id);
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("bounded_active_task_admitter_tb: PASS");
        end else begin
            $display("bounded_active_task_admitter_tb: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/bata_pkg.sv
sv/bata_prio_enc.sv
sv/bata_slot_table.sv
sv/bounded_active_task_admitter.sv
sv/bata_checker.sv
tb/bata_admission_checker.sv
tb/bounded_active_task_admitter_tb.sv
